FILE: hw/rtl/cscan_pkg.sv
// Shared types, constants and a helper function of the C-SCAN disk scheduler.
// Used by every module of the block but cscan_ram; depends on nothing else.
package cscan_pkg;

   localparam int TOTAL_W     = 18;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 18'h3FFFF;
   localparam int CYL_MAX_W   = 16;
   localparam int TOP_RESET   = 199;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int CSR_IDX_W   = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAD = 2'd0,
      CSR_TOP  = 2'd1
   } csr_index_type;

   // Flags the front end attaches to every queued request word.
   typedef struct packed {
      logic last;
      logic drop;
   } entry_flags_type;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

   // Sweep phases: first request set, two end-of-disk moves, second request set.
   typedef enum logic [3:0] {
      PH_FIRST  = 4'b0001,
      PH_FIX1   = 4'b0010,
      PH_FIX2   = 4'b0100,
      PH_SECOND = 4'b1000
   } phase_type;

   function automatic logic [CYL_MAX_W-1:0] cyl_absdiff(input logic [CYL_MAX_W-1:0] a,
                                                        input logic [CYL_MAX_W-1:0] b);
      cyl_absdiff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

FILE: hw/rtl/cscan_disk_scheduler_top.sv
// C-SCAN disk scheduler: collects a batch of cylinder requests and issues the
// circular-scan service order as a series of head moves.
//
// Request channel (req_): one word per request; req_batch_end marks the last
// word of a batch. Words are taken at one per cycle while the back end loads,
// through a four-word queue; req_stall rises only when that queue is full.
// Move channel (rsp_): a batch of n stored requests yields n + 2 move words,
// each with from, to, distance, running total, the dropped flag and a final
// marker. Moves come from an output register, so a stalled word holds while
// the scheduler keeps working up to the next move.
// Each move to a stored request follows a scan of the request store through
// its single read port, one entry per cycle; the two end-of-disk moves follow
// one more scan that finds the first set used up. The next batch is loaded
// only after the final move of a batch has been issued. Requests beyond
// MAX_REQUESTS are dropped and flagged.
// Configuration (csr_): head position at index 0, top cylinder at index 1,
// written while the block is idle; the user must keep to this, as the block
// itself does not enforce it. Reset empties the queue and the store and
// sets head 0 and top 199; no move word is pending after reset.
module cscan_disk_scheduler_top #(
   parameter int MAX_REQUESTS = 16,
   parameter int CYL_BITS     = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [cscan_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [CYL_BITS-1:0]             csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [CYL_BITS-1:0]             req_request_cylinder,
   input  logic                            req_batch_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [CYL_BITS-1:0]             rsp_move_from,
   output logic [CYL_BITS-1:0]             rsp_move_to,
   output logic [CYL_BITS-1:0]             rsp_move_distance,
   output logic [cscan_pkg::TOTAL_W-1:0]   rsp_running_total,
   output logic                            rsp_dropped_flag,
   output logic                            rsp_final_move
);

   logic [CYL_BITS-1:0] head_ff, head_in;
   logic [CYL_BITS-1:0] top_ff, top_in;
   logic                q_full, q_push, q_valid, q_pop;
   logic [CYL_BITS+1:0] q_wdata, q_rdata;

   always_comb begin
      head_in = head_ff;
      top_in  = top_ff;
      if (csr_we) begin
         unique case (cscan_pkg::csr_index_type'(csr_index))
            cscan_pkg::CSR_HEAD: head_in = csr_wdata;
            cscan_pkg::CSR_TOP:  top_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         top_ff  <= CYL_BITS'(cscan_pkg::TOP_RESET);
      end else begin
         head_ff <= head_in;
         top_ff  <= top_in;
      end
   end

   cscan_front #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .CYL_BITS     (CYL_BITS)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_request_cylinder (req_request_cylinder),
      .req_batch_end        (req_batch_end),
      .q_full               (q_full),
      .q_push               (q_push),
      .q_data               (q_wdata)
   );

   cscan_fifo #(
      .WIDTH (CYL_BITS + 2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rdata)
   );

   cscan_back #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .CYL_BITS     (CYL_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_data            (q_rdata),
      .q_pop             (q_pop),
      .head              (head_ff),
      .top               (top_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_move_from     (rsp_move_from),
      .rsp_move_to       (rsp_move_to),
      .rsp_move_distance (rsp_move_distance),
      .rsp_running_total (rsp_running_total),
      .rsp_dropped_flag  (rsp_dropped_flag),
      .rsp_final_move    (rsp_final_move)
   );

   // Every move word carries the distance between its two end points.
   a_move_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_move_distance == CYL_BITS'(cscan_pkg::cyl_absdiff(
         cscan_pkg::CYL_MAX_W'(rsp_move_from), cscan_pkg::CYL_MAX_W'(rsp_move_to))))
      else $error("move distance does not match its end points");

   // A stalled move word stays on offer with its end points, running total and final marker unchanged.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_move_from)
         && $stable(rsp_move_to) && $stable(rsp_running_total) && $stable(rsp_final_move))
      else $error("stalled move word changed");

   // Reset leaves no pending move and an empty queue.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

endmodule

FILE: hw/rtl/cscan_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the request store of the scheduler.
module cscan_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/cscan_front.sv
// Front end of the scheduler: accepts request words and marks those that
// overflow the batch store. Uses cscan_pkg for the flag struct.
module cscan_front #(
   parameter int MAX_REQUESTS = 16,
   parameter int CYL_BITS     = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CYL_BITS-1:0]   req_request_cylinder,
   input  logic                  req_batch_end,
   input  logic                  q_full,
   output logic                  q_push,
   output logic [CYL_BITS+1:0]   q_data
);

   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

   logic [CNT_W-1:0]           fcnt_ff;
   logic [CNT_W-1:0]           fcnt_in;
   cscan_pkg::entry_flags_type flags;

   assign req_stall  = q_full;
   assign q_push     = req_valid && !q_full;
   assign flags      = '{last: req_batch_end, drop: (fcnt_ff == CNT_W'(MAX_REQUESTS))};
   assign q_data     = {flags, req_request_cylinder};

   // The count tracks the stored words of the batch being accepted and clears when its last word is queued.
   always_comb begin
      fcnt_in = fcnt_ff;
      if (q_push) begin
         if (req_batch_end) begin
            fcnt_in = '0;
         end else if (!flags.drop) begin
            fcnt_in = fcnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff <= '0;
      end else begin
         fcnt_ff <= fcnt_in;
      end
   end

endmodule

FILE: hw/rtl/cscan_fifo.sv
// Short queue between the front and back ends of the scheduler.
// Depth comes from cscan_pkg; payload width is a parameter.
module cscan_fifo #(
   parameter int WIDTH = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = cscan_pkg::QUEUE_AW;

   logic [WIDTH-1:0] entry_ff [cscan_pkg::QUEUE_DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW-1:0]    rd_ptr_in;
   logic [AW:0]      level_ff;
   logic [AW:0]      level_in;

   assign full     = (level_ff == (AW+1)'(cscan_pkg::QUEUE_DEPTH));
   assign valid    = (level_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + (AW+1)'(1);
      end else if (pop && !push) begin
         level_in = level_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

FILE: hw/rtl/cscan_back.sv
// Back end of the scheduler: stores a batch, then finds each next stop by a
// scan over the request store and issues one move word per stop.
// Uses cscan_pkg and one cscan_ram instance.
module cscan_back #(
   parameter int MAX_REQUESTS = 16,
   parameter int CYL_BITS     = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  logic [CYL_BITS+1:0]                  q_data,
   output logic                                 q_pop,
   input  logic [CYL_BITS-1:0]                  head,
   input  logic [CYL_BITS-1:0]                  top,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [CYL_BITS-1:0]                  rsp_move_from,
   output logic [CYL_BITS-1:0]                  rsp_move_to,
   output logic [CYL_BITS-1:0]                  rsp_move_distance,
   output logic [cscan_pkg::TOTAL_W-1:0]        rsp_running_total,
   output logic                                 rsp_dropped_flag,
   output logic                                 rsp_final_move
);

   localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
   localparam int MCNT_W = $clog2(MAX_REQUESTS + 2);
   localparam int TW     = cscan_pkg::TOTAL_W;
   localparam int MW     = cscan_pkg::CYL_MAX_W;

   cscan_pkg::back_state_type  state_ff, state_in;
   cscan_pkg::phase_type       ph_ff, ph_in;
   cscan_pkg::entry_flags_type q_flags;

   logic [CYL_BITS-1:0]     q_cyl;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    overflow_ff, overflow_in;
   logic [TW-1:0]           total_ff, total_in;
   logic [MAX_REQUESTS-1:0] used_ff, used_in;
   logic [CYL_BITS-1:0]     head_ff, head_in;
   logic [CYL_BITS-1:0]     top_ff, top_in;
   logic                    far_ff, far_in;
   logic [CYL_BITS-1:0]     cur_ff, cur_in;
   logic [MCNT_W-1:0]       mcnt_ff, mcnt_in;
   logic [CNT_W-1:0]        scan_addr_ff, scan_addr_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    found_ff, found_in;
   logic [CYL_BITS-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;

   logic                    out_vld_ff, out_vld_in;
   logic [CYL_BITS-1:0]     out_from_ff, out_to_ff, out_dist_ff;
   logic [TW-1:0]           out_total_ff;
   logic                    out_drop_ff, out_final_ff;

   logic [CYL_BITS-1:0]     rd_data;
   logic [CYL_BITS-1:0]     clamped;
   logic                    issue, want_upper, in_upper, better, cand, scan_done;
   logic                    slot_free, emit_fire, is_final, far_now;
   logic [CYL_BITS-1:0]     target, hop_dist;
   logic [TW:0]             sum;
   logic [TW-1:0]           total_next;

   assign q_cyl   = q_data[CYL_BITS-1:0];
   assign q_flags = cscan_pkg::entry_flags_type'(q_data[CYL_BITS+1:CYL_BITS]);
   assign q_pop   = (state_ff == cscan_pkg::ST_LOAD) && q_valid;

   cscan_ram #(
      .WIDTH (CYL_BITS),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (q_pop && !q_flags.drop),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (q_cyl),
      .rd_en   (issue),
      .rd_addr (scan_addr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Scan datapath: one stored request is examined per cycle.
   assign issue      = (state_ff == cscan_pkg::ST_SCAN) && (scan_addr_ff < count_ff);
   assign clamped    = (rd_data > top_ff) ? top_ff : rd_data;
   assign in_upper   = (clamped >= head_ff);
   assign want_upper = (ph_ff == cscan_pkg::PH_FIRST) ? far_ff : !far_ff;
   assign better     = far_ff ? (clamped < best_ff) : (clamped > best_ff);
   assign cand       = rd_vld_ff && !used_ff[rd_idx_ff] && (in_upper == want_upper)
                       && (!found_ff || better);
   assign scan_done  = (state_ff == cscan_pkg::ST_SCAN) && !issue && !rd_vld_ff;

   assign far_now = (MW'(head) >= cscan_pkg::cyl_absdiff(MW'(head), MW'(top)));

   always_comb begin
      unique case (ph_ff) inside
         cscan_pkg::PH_FIX1: target = far_ff ? top_ff : '0;
         cscan_pkg::PH_FIX2: target = far_ff ? '0 : top_ff;
         default:            target = best_ff;
      endcase
   end

   assign hop_dist   = CYL_BITS'(cscan_pkg::cyl_absdiff(MW'(cur_ff), MW'(target)));
   assign sum        = {1'b0, total_ff} + (TW+1)'(hop_dist);
   assign total_next = sum[TW] ? cscan_pkg::TOTAL_MAX : sum[TW-1:0];
   assign is_final   = (mcnt_ff == MCNT_W'(count_ff) + MCNT_W'(1));
   assign slot_free  = !out_vld_ff || !rsp_stall;
   assign emit_fire  = (state_ff == cscan_pkg::ST_EMIT) && slot_free;

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      total_in     = total_ff;
      used_in      = used_ff;
      head_in      = head_ff;
      top_in       = top_ff;
      far_in       = far_ff;
      cur_in       = cur_ff;
      mcnt_in      = mcnt_ff;
      scan_addr_in = scan_addr_ff;
      rd_vld_in    = issue;
      rd_idx_in    = scan_addr_ff[IDX_W-1:0];
      found_in     = found_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      out_vld_in   = out_vld_ff && rsp_stall;

      unique case (state_ff)
         cscan_pkg::ST_LOAD: begin
            if (q_pop) begin
               if (q_flags.drop) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               // Head and top are sampled when the batch closes.
               if (q_flags.last) begin
                  head_in      = head;
                  top_in       = top;
                  far_in       = far_now;
                  cur_in       = head;
                  mcnt_in      = '0;
                  ph_in        = cscan_pkg::PH_FIRST;
                  scan_addr_in = '0;
                  found_in     = 1'b0;
                  state_in     = cscan_pkg::ST_SCAN;
               end
            end
         end
         cscan_pkg::ST_SCAN: begin
            if (issue) begin
               scan_addr_in = scan_addr_ff + CNT_W'(1);
            end
            if (cand) begin
               found_in    = 1'b1;
               best_in     = clamped;
               best_idx_in = rd_idx_ff;
            end
            if (scan_done) begin
               if (found_ff) begin
                  state_in = cscan_pkg::ST_EMIT;
               end else if (ph_ff == cscan_pkg::PH_FIRST) begin
                  ph_in    = cscan_pkg::PH_FIX1;
                  state_in = cscan_pkg::ST_EMIT;
               end else begin
                  state_in = cscan_pkg::ST_LOAD;
               end
            end
         end
         cscan_pkg::ST_EMIT: begin
            if (emit_fire) begin
               out_vld_in = 1'b1;
               cur_in     = target;
               total_in   = total_next;
               mcnt_in    = mcnt_ff + MCNT_W'(1);
               if (ph_ff == cscan_pkg::PH_FIRST || ph_ff == cscan_pkg::PH_SECOND) begin
                  used_in[best_idx_ff] = 1'b1;
               end
               scan_addr_in = '0;
               found_in     = 1'b0;
               if (is_final) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  total_in    = '0;
                  used_in     = '0;
                  state_in    = cscan_pkg::ST_LOAD;
               end else begin
                  unique case (ph_ff) inside
                     cscan_pkg::PH_FIX1: ph_in = cscan_pkg::PH_FIX2;
                     cscan_pkg::PH_FIX2: begin
                        ph_in    = cscan_pkg::PH_SECOND;
                        state_in = cscan_pkg::ST_SCAN;
                     end
                     default: state_in = cscan_pkg::ST_SCAN;
                  endcase
               end
            end
         end
         default: state_in = cscan_pkg::ST_LOAD;
      endcase

      // A batch that runs dry early is closed without leaving stale state behind.
      if (state_ff == cscan_pkg::ST_SCAN && scan_done && !found_ff
          && ph_ff != cscan_pkg::PH_FIRST) begin
         count_in    = '0;
         overflow_in = 1'b0;
         total_in    = '0;
         used_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= cscan_pkg::ST_LOAD;
         ph_ff       <= cscan_pkg::PH_FIRST;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         total_ff    <= '0;
         used_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         found_ff    <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ph_ff       <= ph_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         total_ff    <= total_in;
         used_ff     <= used_in;
         rd_vld_ff   <= rd_vld_in;
         found_ff    <= found_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff      <= head_in;
      top_ff       <= top_in;
      far_ff       <= far_in;
      cur_ff       <= cur_in;
      mcnt_ff      <= mcnt_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= rd_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      if (emit_fire) begin
         out_from_ff  <= cur_ff;
         out_to_ff    <= target;
         out_dist_ff  <= hop_dist;
         out_total_ff <= total_next;
         out_drop_ff  <= overflow_ff;
         out_final_ff <= is_final;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_move_from     = out_from_ff;
   assign rsp_move_to       = out_to_ff;
   assign rsp_move_distance = out_dist_ff;
   assign rsp_running_total = out_total_ff;
   assign rsp_dropped_flag  = out_drop_ff;
   assign rsp_final_move    = out_final_ff;

endmodule
